/* hw/rtl/hci_rx_pkg.sv */
// shared types and constants for the hci h4 receive deframer
// no dependencies; imported by every module of the block
package hci_rx_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_EVENT_TYPE = 2'd0;
	localparam logic [1:0] CFG_ACL_TYPE   = 2'd1;

	// reset values of the type codes
	localparam logic [7:0] EVENT_TYPE_RESET = 8'h04;
	localparam logic [7:0] ACL_TYPE_RESET   = 8'h02;

	// masks on the acl flags byte
	localparam logic [7:0] HANDLE_HI_MASK = 8'h0F;
	localparam logic [1:0] FLAG_MASK      = 2'h3;

	// record and packet kinds
	localparam logic REC_HEADER  = 1'b0;
	localparam logic REC_PAYLOAD = 1'b1;
	localparam logic PKT_EVENT   = 1'b0;
	localparam logic PKT_ACL     = 1'b1;

	// deframer phase
	typedef enum logic [1:0] {
		PH_WAIT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} hci_phase_t;

	// live configuration
	typedef struct packed {
		logic [7:0] event_type_code;
		logic [7:0] acl_type_code;
	} hci_cfg_t;

	// one output record
	typedef struct packed {
		logic        record_kind;
		logic        packet_kind;
		logic [7:0]  evt_id;
		logic [11:0] link_handle;
		logic [1:0]  boundary_flag;
		logic [1:0]  broadcast_flag;
		logic [15:0] payload_length;
		logic [15:0] payload_index;
		logic [7:0]  data_byte;
		logic        last_of_packet;
	} hci_rec_t;

endpackage

/* hw/rtl/hci_rx_cfg.sv */
// configuration registers of the hci h4 receive deframer
// depends on hci_rx_pkg
module hci_rx_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output hci_rx_pkg::hci_cfg_t cfg
);
	import hci_rx_pkg::*;

	logic [7:0] event_type_q;
	logic [7:0] acl_type_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_type_q <= EVENT_TYPE_RESET;
			acl_type_q   <= ACL_TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EVENT_TYPE: event_type_q <= cfg_data;
				CFG_ACL_TYPE:   acl_type_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.event_type_code = event_type_q;
	assign cfg.acl_type_code   = acl_type_q;

endmodule

/* hw/rtl/hci_rx_fsm.sv */
// packet state machine: parses type and header bytes, builds a header record and one record per payload byte
// depends on hci_rx_pkg
module hci_rx_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hci_rx_pkg::hci_cfg_t cfg,
	input  logic                 in_fire,
	input  logic [7:0]           rx_byte,
	output logic                 rec_valid,
	output hci_rx_pkg::hci_rec_t rec
);
	import hci_rx_pkg::*;

	hci_phase_t  phase_q, phase_d;
	logic        is_data_q, is_data_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] exp_len_q, exp_len_d;
	logic [15:0] pay_cnt_q, pay_cnt_d;

	logic        hdr_done;
	logic [15:0] hdr_len;
	logic [15:0] pay_inc;
	logic        pay_last;

	// header completion and payload end detection
	always_comb begin
		hdr_done = 1'b0;
		hdr_len  = exp_len_q;
		if (phase_q == PH_HEADER && hdr_cnt_q != 2'd0) begin
			if (!is_data_q) begin
				hdr_done = 1'b1;
				hdr_len  = {8'd0, rx_byte};
			end else if (hdr_cnt_q == 2'd3) begin
				hdr_done = 1'b1;
				hdr_len  = {rx_byte, len_lo_q};
			end
		end
	end

	assign pay_inc  = pay_cnt_q + 16'd1;
	assign pay_last = (pay_inc == exp_len_q);

	// next state
	always_comb begin
		phase_d   = phase_q;
		is_data_d = is_data_q;
		hdr_cnt_d = hdr_cnt_q;
		code_d    = code_q;
		flags_d   = flags_q;
		len_lo_d  = len_lo_q;
		exp_len_d = exp_len_q;
		pay_cnt_d = pay_cnt_q;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_done) begin
					exp_len_d = hdr_len;
					hdr_cnt_d = 2'd0;
					pay_cnt_d = 16'd0;
					phase_d   = (hdr_len == 16'd0) ? PH_WAIT : PH_PAYLOAD;
				end else begin
					case (hdr_cnt_q)
						2'd0:    code_d   = rx_byte;
						2'd1:    flags_d  = rx_byte;
						default: len_lo_d = rx_byte;
					endcase
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				if (pay_last) begin
					phase_d   = PH_WAIT;
					pay_cnt_d = 16'd0;
				end else begin
					pay_cnt_d = pay_inc;
				end
			end
			default: begin
				// waiting for a type byte; event code wins a tie
				phase_d   = PH_WAIT;
				hdr_cnt_d = 2'd0;
				if (rx_byte == cfg.event_type_code) begin
					is_data_d = PKT_EVENT;
					phase_d   = PH_HEADER;
				end else if (rx_byte == cfg.acl_type_code) begin
					is_data_d = PKT_ACL;
					phase_d   = PH_HEADER;
				end
			end
		endcase
	end

	// record fields
	always_comb begin
		rec           = '0;
		rec_valid     = 1'b0;
		rec.packet_kind = is_data_q;
		if (is_data_q) begin
			rec.link_handle    = {flags_q[3:0] & HANDLE_HI_MASK[3:0], code_q};
			rec.boundary_flag  = flags_q[5:4] & FLAG_MASK;
			rec.broadcast_flag = flags_q[7:6] & FLAG_MASK;
		end else begin
			rec.evt_id = code_q;
		end
		case (phase_q)
			PH_HEADER: begin
				rec_valid          = hdr_done;
				rec.record_kind    = REC_HEADER;
				rec.payload_length = hdr_len;
				rec.last_of_packet = (hdr_len == 16'd0);
			end
			PH_PAYLOAD: begin
				rec_valid          = 1'b1;
				rec.record_kind    = REC_PAYLOAD;
				rec.payload_length = exp_len_q;
				rec.payload_index  = pay_cnt_q;
				rec.data_byte      = rx_byte;
				rec.last_of_packet = pay_last;
			end
			default: rec_valid = 1'b0;
		endcase
	end

	// state registers, advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			is_data_q <= 1'b0;
			hdr_cnt_q <= 2'd0;
			code_q    <= 8'd0;
			flags_q   <= 8'd0;
			len_lo_q  <= 8'd0;
			exp_len_q <= 16'd0;
			pay_cnt_q <= 16'd0;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			is_data_q <= is_data_d;
			hdr_cnt_q <= hdr_cnt_d;
			code_q    <= code_d;
			flags_q   <= flags_d;
			len_lo_q  <= len_lo_d;
			exp_len_q <= exp_len_d;
			pay_cnt_q <= pay_cnt_d;
		end
	end

`ifndef NO_ASSERTIONS
	// payload phase never runs with an empty packet
	a_pay_len: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (exp_len_q != 16'd0))
		else $error("payload phase with zero length");

	// payload index stays below the announced length
	a_pay_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pay_cnt_q < exp_len_q))
		else $error("payload index past length");

	// header counter is idle outside the header phase
	a_hdr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> (hdr_cnt_q == 2'd0))
		else $error("header counter not cleared");
`endif

endmodule

/* hw/rtl/hci_rx_skid.sv */
// two-entry output buffer for records, keeps the input ready registered
// depends on hci_rx_pkg
module hci_rx_skid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hci_rx_pkg::hci_rec_t push_rec,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hci_rx_pkg::hci_rec_t out_rec
);
	import hci_rx_pkg::*;

	logic     main_valid_q;
	logic     skid_valid_q;
	hci_rec_t main_q;
	hci_rec_t skid_q;
	logic     take;
	logic     main_free;

	assign take      = main_valid_q && out_ready;
	assign main_free = take || !main_valid_q;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_rec   = main_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_rec;
		end else if (push) begin
			skid_q <= push_rec;
		end
	end

`ifndef NO_ASSERTIONS
	// the skid entry is only ever used behind a full main entry
	a_skid_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry without main entry");

	// no record arrives while both entries are full
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("record pushed into full buffer");

	// a stalled skid entry keeps its record
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ready) |=> (skid_valid_q && $stable(skid_q)))
		else $error("skid entry lost while stalled");
`endif

endmodule

/* hw/rtl/hci_h4_rx_deframer_top.sv */
// top level of the hci h4 receive deframer: stream ports and config port
// depends on hci_rx_pkg, hci_rx_cfg, hci_rx_fsm, hci_rx_skid
//
// The deframer takes one received UART byte per clock on the s_ side while
// s_tready is high and parses HCI H4 packets: a type byte matching
// event_type_code or acl_type_code opens a packet, other type bytes are
// dropped. When the last header byte arrives a header record is produced,
// then one record per payload byte, the final one flagged with m_tlast (a
// zero-length packet ends at its header record). Each record is registered
// in the output buffer before it appears on the m_ side. A two-entry output
// buffer lets s_tready stay high while one record waits on m_tready, and
// drops it only when both entries are occupied. Type-code writes take
// effect at the next type byte and are always accepted.
module hci_h4_rx_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// record stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] evt_id, [19:8] link_handle,
	                               // [21:20] boundary_flag, [23:22] broadcast_flag,
	                               // [39:24] payload_length, [55:40] payload_index,
	                               // [63:56] data_byte
	output logic [1:0]  m_tuser,   // [0] record_kind, [1] packet_kind
	output logic        m_tlast,   // last_of_packet
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import hci_rx_pkg::*;

	hci_cfg_t cfg;
	hci_rec_t rec;
	hci_rec_t out_rec;
	logic     rec_valid;
	logic     in_fire;
	logic     space;

	assign s_tready = space;
	assign in_fire  = s_tvalid && s_tready;

	// type code registers
	hci_rx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// packet parser
	hci_rx_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_fire   (in_fire),
		.rx_byte   (s_tdata),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// output buffer
	hci_rx_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire && rec_valid),
		.push_rec  (rec),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec)
	);

	// pack the record onto the stream
	assign m_tdata = {out_rec.data_byte, out_rec.payload_index, out_rec.payload_length,
		out_rec.broadcast_flag, out_rec.boundary_flag, out_rec.link_handle,
		out_rec.evt_id};
	assign m_tuser = {out_rec.packet_kind, out_rec.record_kind};
	assign m_tlast = out_rec.last_of_packet;

endmodule

/* test/hci_h4_rx_deframer_top_test.sv */
// self-checking testbench for the hci h4 receive deframer top level
// drives the byte stream and config port, predicts every record in-line
// depends on hci_rx_pkg and hci_h4_rx_deframer_top
module hci_h4_rx_deframer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hci_rx_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int TIMEOUT_NS    = 200_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_EVENT_TYPE;
	logic [7:0]  cfg_data = 8'h00;

	hci_h4_rx_deframer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bytes waiting to be offered, records waiting to come out
	logic [7:0] uart_bytes[$];
	hci_rec_t   expected_records[$];
	bit         byte_offered = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int mismatches = 0;
	int records_checked = 0;
	int bytes_taken = 0;
	int packets_queued = 0;
	int broken_headers = 0;
	int noise_bytes = 0;

	// deframer model state and type codes
	logic [7:0]  evt_code_reg = EVENT_TYPE_RESET;
	logic [7:0]  acl_code_reg = ACL_TYPE_RESET;
	hci_phase_t  frame_phase = PH_WAIT;
	logic        is_acl = 1'b0;
	logic [2:0]  hdr_count = 3'd0;
	logic [7:0]  code_or_handle_lo = 8'h00;
	logic [7:0]  flags_byte = 8'h00;
	logic [7:0]  len_lo = 8'h00;
	logic [15:0] pay_len = 16'h0000;
	logic [15:0] pay_count = 16'h0000;

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// header part shared by header and payload records
	function automatic hci_rec_t header_fields();
		hci_rec_t r;
		r = '0;
		r.packet_kind = is_acl ? PKT_ACL : PKT_EVENT;
		if (is_acl) begin
			r.link_handle = {4'(flags_byte & HANDLE_HI_MASK), code_or_handle_lo};
			r.boundary_flag = flags_byte[5:4] & FLAG_MASK;
			r.broadcast_flag = flags_byte[7:6] & FLAG_MASK;
		end else begin
			r.evt_id = code_or_handle_lo;
		end
		r.payload_length = pay_len;
		return r;
	endfunction

	// advance the deframer model by one byte, queue the record it yields
	task automatic deframe_byte(input logic [7:0] b);
		hci_rec_t rec;
		logic     done;
		logic     last;
		done = 1'b0;
		case (frame_phase)
		PH_HEADER: begin
			if (hdr_count == 3'd0) begin
				code_or_handle_lo = b;
				hdr_count = 3'd1;
			end else if (!is_acl) begin
				pay_len = {8'h00, b};
				done = 1'b1;
			end else if (hdr_count == 3'd1) begin
				flags_byte = b;
				hdr_count = 3'd2;
			end else if (hdr_count == 3'd2) begin
				len_lo = b;
				hdr_count = 3'd3;
			end else begin
				pay_len = {b, len_lo};
				done = 1'b1;
			end
			if (done) begin
				hdr_count = 3'd0;
				pay_count = 16'h0000;
				rec = header_fields();
				rec.record_kind = REC_HEADER;
				rec.last_of_packet = (pay_len == 16'h0000);
				frame_phase = (pay_len == 16'h0000) ? PH_WAIT : PH_PAYLOAD;
				expected_records.push_back(rec);
			end
		end
		PH_PAYLOAD: begin
			last = (16'(pay_count + 16'd1) == pay_len);
			rec = header_fields();
			rec.record_kind = REC_PAYLOAD;
			rec.payload_index = pay_count;
			rec.data_byte = b;
			rec.last_of_packet = last;
			pay_count = pay_count + 16'd1;
			if (last) begin
				frame_phase = PH_WAIT;
				pay_count = 16'h0000;
			end
			expected_records.push_back(rec);
		end
		default: begin
			// waiting for a type byte; event code wins when both match
			frame_phase = PH_WAIT;
			hdr_count = 3'd0;
			if (b == evt_code_reg) begin
				is_acl = 1'b0;
				frame_phase = PH_HEADER;
			end else if (b == acl_code_reg) begin
				is_acl = 1'b1;
				frame_phase = PH_HEADER;
			end
		end
		endcase
	endtask

	function automatic string rec_text(input hci_rec_t r);
		return $sformatf({"kind=%0d pkt=%0d evt=%02h hdl=%03h pb=%0d bc=%0d",
			" len=%0d idx=%0d data=%02h last=%0d"},
			r.record_kind, r.packet_kind, r.evt_id, r.link_handle,
			r.boundary_flag, r.broadcast_flag, r.payload_length, r.payload_index,
			r.data_byte, r.last_of_packet);
	endfunction

	// byte driver: holds a word until taken, idles at random between words
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!byte_offered) begin
			if (uart_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= uart_bytes[0];
				byte_offered = 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// record sink back-pressure
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: check records out, feed accepted bytes to the model
	always @(posedge clk) begin
		hci_rec_t got;
		hci_rec_t want;
		logic [7:0] b;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.record_kind = m_tuser[0];
				got.packet_kind = m_tuser[1];
				got.evt_id = m_tdata[7:0];
				got.link_handle = m_tdata[19:8];
				got.boundary_flag = m_tdata[21:20];
				got.broadcast_flag = m_tdata[23:22];
				got.payload_length = m_tdata[39:24];
				got.payload_index = m_tdata[55:40];
				got.data_byte = m_tdata[63:56];
				got.last_of_packet = m_tlast;
				if (expected_records.size() == 0) begin
					mismatches++;
					$display("%0t ERROR unexpected record: expected none, got %s",
						$time, rec_text(got));
				end else begin
					want = expected_records.pop_front();
					records_checked++;
					if (got !== want) begin
						mismatches++;
						$display("%0t ERROR record mismatch: expected %s, got %s",
							$time, rec_text(want), rec_text(got));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				b = uart_bytes.pop_front();
				byte_offered = 1'b0;
				bytes_taken++;
				deframe_byte(b);
			end
		end
	end

	// one config write; the model takes the new code at the handshake
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_EVENT_TYPE)
			evt_code_reg = val;
		else if (idx == CFG_ACL_TYPE)
			acl_code_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every byte is taken and every record has come out
	task automatic wait_drained();
		while (uart_bytes.size() != 0 || byte_offered || expected_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one well-formed packet with random header and payload content
	task automatic queue_packet(input bit acl, input logic [15:0] len, output int unsigned n);
		if (acl) begin
			uart_bytes.push_back(acl_code_reg);
			uart_bytes.push_back(8'($urandom));
			uart_bytes.push_back(8'($urandom));
			uart_bytes.push_back(len[7:0]);
			uart_bytes.push_back(len[15:8]);
			n = 5;
		end else begin
			uart_bytes.push_back(evt_code_reg);
			uart_bytes.push_back(8'($urandom));
			uart_bytes.push_back(len[7:0]);
			n = 3;
		end
		repeat (len) uart_bytes.push_back(8'($urandom));
		n += len;
		packets_queued++;
	endtask

	// mostly packets with short payloads, some noise and cut-off headers
	task automatic queue_random(input int unsigned n_bytes);
		int unsigned sent;
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		bit acl;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				uart_bytes.push_back(8'($urandom));
				noise_bytes++;
				sent += 1;
			end else if (pick < 15) begin
				uart_bytes.push_back($urandom_range(0, 1) ? acl_code_reg : evt_code_reg);
				len = $urandom_range(0, 2);
				repeat (len) uart_bytes.push_back(8'($urandom));
				sent += len + 1;
				broken_headers++;
			end else begin
				acl = 1'($urandom_range(0, 1));
				len = $urandom_range(0, 6);
				queue_packet(acl, 16'(len), n);
				sent += n;
			end
		end
	endtask

	// stimulus sequence
	initial begin
		logic [7:0] directed[];
		int unsigned n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset codes; unknown types, zero-length and short packets at the extremes
		send_idle_pct = 12;
		recv_idle_pct = 61;
		directed = '{8'h00, 8'hFF,
			8'h04, 8'hFF, 8'h00,
			8'h04, 8'h00, 8'h02, 8'hAA, 8'h55,
			8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h02, 8'h00, 8'h00, 8'h01, 8'h00, 8'h3C};
		foreach (directed[i]) uart_bytes.push_back(directed[i]);
		// sender holds off until all records are out
		wait_drained();
		queue_random(80);
		// leave an acl header half done across the code change
		uart_bytes.push_back(acl_code_reg);
		uart_bytes.push_back(8'h34);
		wait_drained();

		// extreme codes; the open packet finishes under its old type
		write_reg(CFG_EVENT_TYPE, 8'hFF);
		write_reg(CFG_ACL_TYPE, 8'h00);
		send_idle_pct = 61;
		recv_idle_pct = 12;
		directed = '{8'hC5, 8'h02, 8'h00, 8'h11, 8'h22};
		foreach (directed[i]) uart_bytes.push_back(directed[i]);
		queue_random(90);
		wait_drained();

		// both codes equal, so every packet parses as an event
		write_reg(CFG_EVENT_TYPE, 8'h5A);
		write_reg(CFG_ACL_TYPE, 8'h5A);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(40);
		wait_drained();

		// back to reset codes, plus one acl packet whose length needs the high byte
		write_reg(CFG_EVENT_TYPE, EVENT_TYPE_RESET);
		write_reg(CFG_ACL_TYPE, ACL_TYPE_RESET);
		queue_random(30);
		queue_packet(1'b1, 16'h0100, n);
		wait_drained();

		$display("covered %0d bytes, %0d packets, %0d cut-off headers, %0d noise bytes",
			bytes_taken, packets_queued, broken_headers, noise_bytes);
		$display("checked %0d records over four type-code settings, %0d mismatches",
			records_checked, mismatches);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("%0t timeout with %0d records outstanding", $time, expected_records.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
